/* rtl/uoa_pkg.sv */
// shared types, codes and helper functions for the obstacle avoider
`default_nettype none

package uoa_pkg;

    // stored distance width
    localparam int DIST_WIDTH = 16;
    // common width for distance compares
    localparam int CMP_WIDTH = 32;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    // request types
    localparam logic [1:0] REQ_READING = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_STEP    = 2'd2;

    // sensor selects
    localparam logic [1:0] SEN_LEFT  = 2'd0;
    localparam logic [1:0] SEN_RIGHT = 2'd1;
    localparam logic [1:0] SEN_FRONT = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FRONT_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_VALID       = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FORWARD_SPEED   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TURN_RATE       = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TURN_TIME       = 3'd4;

    // mode codes as seen on the result
    localparam logic [1:0] CODE_STOP    = 2'd0;
    localparam logic [1:0] CODE_FORWARD = 2'd1;
    localparam logic [1:0] CODE_LEFT    = 2'd2;
    localparam logic [1:0] CODE_RIGHT   = 2'd3;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        MODE_STOP    = 4'b0001,
        MODE_FORWARD = 4'b0010,
        MODE_LEFT    = 4'b0100,
        MODE_RIGHT   = 4'b1000
    } mode_t;

    typedef logic [DIST_WIDTH-1:0] dist_t;

    typedef struct packed {
        logic [15:0] front_threshold_mm;
        logic [15:0] min_valid_mm;
        logic [15:0] forward_speed;
        logic [14:0] turn_rate;
        logic [15:0] turn_time_ms;
    } cfg_t;

    // write and tick controls into the sensor bank
    typedef struct packed {
        logic  wr_en;
        logic  [1:0] sel;
        dist_t wr_dist;
        logic  tick;
    } bank_ctrl_t;

    // stored readings and timer out of the sensor bank
    typedef struct packed {
        dist_t       left;
        dist_t       right;
        dist_t       front;
        logic [15:0] turn_elapsed_ms;
    } sense_t;

    // status out of the mode machine
    typedef struct packed {
        mode_t mode;
        logic  timer_clear;
    } fsm_stat_t;

    function automatic dist_t dist_fit(input logic [15:0] raw);
        logic [31:0] wide;
        wide = 32'(raw);
        return wide[DIST_WIDTH-1:0];
    endfunction

    function automatic logic [CMP_WIDTH-1:0] widen(input dist_t d);
        return CMP_WIDTH'(d);
    endfunction

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] code;
        unique case (m)
            MODE_STOP:    code = CODE_STOP;
            MODE_FORWARD: code = CODE_FORWARD;
            MODE_LEFT:    code = CODE_LEFT;
            MODE_RIGHT:   code = CODE_RIGHT;
            default:      code = CODE_STOP;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/uoa_if.sv */
// item channel interfaces for commands in and velocity results out
`default_nettype none

interface uoa_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  sensor_select;
    logic [15:0] distance_mm;

    modport source (output valid, output req_type, output sensor_select,
                    output distance_mm, input ready);
    modport sink   (input valid, input req_type, input sensor_select,
                    input distance_mm, output ready);
endinterface

interface uoa_vel_if;
    logic               valid;
    logic               ready;
    logic        [15:0] linear_speed;
    logic signed [15:0] angular_speed;
    logic        [1:0]  mode_now;

    modport source (output valid, output linear_speed, output angular_speed,
                    output mode_now, input ready);
    modport sink   (input valid, input linear_speed, input angular_speed,
                    input mode_now, output ready);
endinterface

`default_nettype wire

/* rtl/uoa_sensor_bank.sv */
// distance registers for left, right and front plus the saturating turn timer
`default_nettype none

module uoa_sensor_bank (
    input  wire                 clk,
    input  wire                 rst_n,
    input  uoa_pkg::bank_ctrl_t ctrl,
    input  wire                 timer_clear,
    output uoa_pkg::sense_t     sense
);

    uoa_pkg::dist_t left_reg, left_next;
    uoa_pkg::dist_t right_reg, right_next;
    uoa_pkg::dist_t front_reg, front_next;
    logic [15:0]    timer_reg, timer_next;

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        front_next = front_reg;
        timer_next = timer_reg;
        if (ctrl.wr_en)
        begin
            unique case (ctrl.sel)
                uoa_pkg::SEN_LEFT:  left_next  = ctrl.wr_dist;
                uoa_pkg::SEN_RIGHT: right_next = ctrl.wr_dist;
                uoa_pkg::SEN_FRONT: front_next = ctrl.wr_dist;
                default: ;  // unknown sensor, dropped
            endcase
        end
        if (timer_clear)
        begin
            timer_next = '0;
        end
        else if (ctrl.tick && timer_reg != uoa_pkg::TIMER_MAX)
        begin
            timer_next = timer_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            front_reg <= '0;
            timer_reg <= '0;
        end
        else
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            front_reg <= front_next;
            timer_reg <= timer_next;
        end
    end

    assign sense.left            = left_reg;
    assign sense.right           = right_reg;
    assign sense.front           = front_reg;
    assign sense.turn_elapsed_ms = timer_reg;

endmodule

`default_nettype wire

/* rtl/uoa_mode_fsm.sv */
// mode state machine and registered velocity result
`default_nettype none

module uoa_mode_fsm (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       step,
    input  uoa_pkg::cfg_t             cfg,
    input  uoa_pkg::sense_t           sense,
    input  wire                       out_ready,
    output logic                      out_valid,
    output logic               [15:0] linear_speed,
    output logic signed        [15:0] angular_speed,
    output logic               [1:0]  mode_now,
    output uoa_pkg::fsm_stat_t        stat
);

    uoa_pkg::mode_t     mode_reg, mode_next;
    logic               valid_reg, valid_next;
    logic        [15:0] lin_reg, lin_next;
    logic signed [15:0] ang_reg, ang_next;
    logic        [1:0]  code_reg, code_next;
    logic               clear;

    logic [uoa_pkg::CMP_WIDTH-1:0] f, l, r, mv, thr;
    logic        [15:0] rate_w;
    logic               obstacle, go_left;

    always_comb
    begin
        f      = uoa_pkg::widen(sense.front);
        l      = uoa_pkg::widen(sense.left);
        r      = uoa_pkg::widen(sense.right);
        mv     = uoa_pkg::CMP_WIDTH'(cfg.min_valid_mm);
        thr    = uoa_pkg::CMP_WIDTH'(cfg.front_threshold_mm);
        rate_w = {1'b0, cfg.turn_rate};
        obstacle = (mv < f) && (thr > f);
        go_left  = ((mv < r) && (l > r)) || ((mv > l) && (r > l));
    end

    always_comb
    begin
        mode_next  = mode_reg;
        clear      = 1'b0;
        valid_next = valid_reg && !out_ready;
        lin_next   = lin_reg;
        ang_next   = ang_reg;
        code_next  = code_reg;
        if (step)
        begin
            valid_next = 1'b1;
            lin_next   = '0;
            ang_next   = '0;
            code_next  = uoa_pkg::mode_code(mode_reg);
            unique case (mode_reg) inside
                uoa_pkg::MODE_STOP:
                begin
                    mode_next = uoa_pkg::MODE_FORWARD;
                end
                uoa_pkg::MODE_FORWARD:
                begin
                    lin_next = cfg.forward_speed;
                    if (obstacle)
                    begin
                        mode_next = go_left ? uoa_pkg::MODE_LEFT : uoa_pkg::MODE_RIGHT;
                        clear     = 1'b1;
                    end
                end
                uoa_pkg::MODE_LEFT, uoa_pkg::MODE_RIGHT:
                begin
                    ang_next = (mode_reg == uoa_pkg::MODE_LEFT) ? signed'(rate_w)
                                                                : signed'(16'd0 - rate_w);
                    if (sense.turn_elapsed_ms >= cfg.turn_time_ms)
                    begin
                        mode_next = uoa_pkg::MODE_FORWARD;
                    end
                end
                default:
                begin
                    mode_next = uoa_pkg::MODE_STOP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= uoa_pkg::MODE_STOP;
            valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lin_reg  <= lin_next;
        ang_reg  <= ang_next;
        code_reg <= code_next;
    end

    assign out_valid        = valid_reg;
    assign linear_speed     = lin_reg;
    assign angular_speed    = ang_reg;
    assign mode_now         = code_reg;
    assign stat.mode        = mode_reg;
    assign stat.timer_clear = clear;

endmodule

`default_nettype wire

/* rtl/ultrasonic_obstacle_avoid_fsm.sv */
// top level of the ultrasonic obstacle avoider: config registers, sensor bank, mode machine
//
// channel  dir  handshake     payload
// cmd      in   valid/ready   req_type, sensor_select, distance_mm
// vel      out  valid/ready   linear_speed, angular_speed, mode_now
// cfg      in   cfg_we only   cfg_index, cfg_data
//
// one item is accepted per cycle while cmd.ready is high; a step item shows its result in the next cycle
// readings and ticks update state at the accept edge and give no result
// cmd.ready drops only while a result waits and vel.ready is low
// reset: mode stop, distances and timer zero, registers at their defaults
`default_nettype none

module ultrasonic_obstacle_avoid_fsm (
    input  wire                                    clk,
    input  wire                                    rst_n,
    uoa_cmd_if.sink                                cmd,
    uoa_vel_if.source                              vel,
    input  wire                                    cfg_we,
    input  wire [uoa_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire [uoa_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

    uoa_pkg::cfg_t      cfg_reg, cfg_next;
    uoa_pkg::bank_ctrl_t bank_ctrl;
    uoa_pkg::sense_t    sense;
    uoa_pkg::fsm_stat_t stat;
    logic               accept;
    logic               step;
    logic               out_valid;

    // register file, writes to unused indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                uoa_pkg::CFG_FRONT_THRESHOLD: cfg_next.front_threshold_mm = cfg_data;
                uoa_pkg::CFG_MIN_VALID:       cfg_next.min_valid_mm       = cfg_data;
                uoa_pkg::CFG_FORWARD_SPEED:   cfg_next.forward_speed      = cfg_data;
                uoa_pkg::CFG_TURN_RATE:       cfg_next.turn_rate          = cfg_data[14:0];
                uoa_pkg::CFG_TURN_TIME:       cfg_next.turn_time_ms       = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.front_threshold_mm <= 16'd500;
            cfg_reg.min_valid_mm       <= 16'd10;
            cfg_reg.forward_speed      <= 16'd100;
            cfg_reg.turn_rate          <= 15'd280;
            cfg_reg.turn_time_ms       <= 16'd1945;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // take a new item unless a finished result is stuck at the output
    assign cmd.ready = !out_valid || vel.ready;
    assign accept    = cmd.valid && cmd.ready;
    // request type three is dropped without a result
    assign step      = accept && (cmd.req_type == uoa_pkg::REQ_STEP);

    assign bank_ctrl.wr_en   = accept && (cmd.req_type == uoa_pkg::REQ_READING);
    assign bank_ctrl.sel     = cmd.sensor_select;
    assign bank_ctrl.wr_dist = uoa_pkg::dist_fit(cmd.distance_mm);
    assign bank_ctrl.tick    = accept && (cmd.req_type == uoa_pkg::REQ_TICK);

    uoa_sensor_bank u_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (bank_ctrl),
        .timer_clear (stat.timer_clear),
        .sense       (sense)
    );

    uoa_mode_fsm u_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .cfg           (cfg_reg),
        .sense         (sense),
        .out_ready     (vel.ready),
        .out_valid     (out_valid),
        .linear_speed  (vel.linear_speed),
        .angular_speed (vel.angular_speed),
        .mode_now      (vel.mode_now),
        .stat          (stat)
    );

    assign vel.valid = out_valid;

    // a step always lands in the output register
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> vel.valid)
        else $error("step item did not produce a result");

    // linear speed only in forward
    a_lin_only_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (vel.valid && vel.mode_now != uoa_pkg::CODE_FORWARD) |-> (vel.linear_speed == 16'd0))
        else $error("linear speed outside forward");

    // angular speed only while turning
    a_ang_only_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (vel.valid && (vel.mode_now == uoa_pkg::CODE_STOP ||
                       vel.mode_now == uoa_pkg::CODE_FORWARD))
        |-> (vel.angular_speed == 16'sd0))
        else $error("angular speed outside a turn");

    // a turn starts with a cleared timer
    a_turn_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(stat.mode) == uoa_pkg::MODE_FORWARD &&
         (stat.mode == uoa_pkg::MODE_LEFT || stat.mode == uoa_pkg::MODE_RIGHT))
        |-> (sense.turn_elapsed_ms == 16'd0))
        else $error("turn started without clearing the timer");

endmodule

`default_nettype wire
